/* hdl/dirty_rectangle_grouper_assert.svh */
// assertion macros for the dirty rectangle grouper
// depends on nothing; included by the top level
`ifndef DIRTY_RECTANGLE_GROUPER_ASSERT_SVH
`define DIRTY_RECTANGLE_GROUPER_ASSERT_SVH
// property checked on every clock edge outside reset
`define DRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked on every clock edge, reset included
`define DRG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* hdl/drg_pkg.sv */
// shared types and constants for the dirty rectangle grouper
// no dependencies
package drg_pkg;
  localparam int STORED_RECTS_DEF = 16;
  localparam int MAX_DIM_DEF      = 16384;
  localparam int CW = 17;   // coordinate width inside the block
  localparam int AW = 35;   // area width

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [14:0] pos_x;
    logic [14:0] pos_y;
    logic [14:0] size_w;
    logic [14:0] size_h;
    logic [3:0]  index;
  } drg_in_t;

  typedef struct packed {
    logic [3:0]  count;
    logic [14:0] rect_x;
    logic [14:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic [14:0] bound_x;
    logic [14:0] bound_y;
    logic [15:0] bound_w;
    logic [15:0] bound_h;
    logic [34:0] total_area;
  } drg_out_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] w;
    logic [CW-1:0] h;
  } box_t;

  // result of the shared join unit
  typedef struct packed {
    box_t          jbox;
    logic [AW-1:0] area_a;
    logic [AW-1:0] cost;
    logic          covers;
  } join_res_t;
endpackage

/* hdl/drg_ram.sv */
// generic single-port-write, one-read ram with registered read
// no dependencies
module drg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/drg_join.sv */
// shared join unit: bounding box of two rectangles, join cost, point test
// depends on drg_pkg; two-stage pipeline so one multiplier stage per cycle
module drg_join
  import drg_pkg::*;
(
  input  logic      clk,
  input  box_t      a,
  input  box_t      b,
  output join_res_t res
);
  box_t          jb_r;
  box_t          a_r, b_r;
  logic          cov_r;
  logic [CW:0]   ra, rb, ba, bb, rr, bo;
  box_t          jb_nxt;
  logic          cov_nxt;
  logic [2*CW-1:0] pa, pb, pj;
  logic [AW:0]   used;

  // stage one: box join and point containment of b's corner in a
  always_comb begin
    ra = {1'b0, a.x} + {1'b0, a.w};
    rb = {1'b0, b.x} + {1'b0, b.w};
    ba = {1'b0, a.y} + {1'b0, a.h};
    bb = {1'b0, b.y} + {1'b0, b.h};
    rr = (ra > rb) ? ra : rb;
    bo = (ba > bb) ? ba : bb;
    jb_nxt.x = (a.x < b.x) ? a.x : b.x;
    jb_nxt.y = (a.y < b.y) ? a.y : b.y;
    jb_nxt.w = CW'(rr - {1'b0, jb_nxt.x});
    jb_nxt.h = CW'(bo - {1'b0, jb_nxt.y});
    cov_nxt = (b.x >= a.x) && ((b.x - a.x) < a.w) &&
              (b.y >= a.y) && ((b.y - a.y) < a.h);
  end

  always_ff @(posedge clk) begin
    jb_r  <= jb_nxt;
    a_r   <= a;
    b_r   <= b;
    cov_r <= cov_nxt;
  end

  // stage two: areas and cost
  always_comb begin
    pa   = a_r.w * a_r.h;
    pb   = b_r.w * b_r.h;
    pj   = jb_r.w * jb_r.h;
    used = (AW+1)'(pa) + (AW+1)'(pb);
    res.jbox   = jb_r;
    res.area_a = AW'(pa);
    res.covers = cov_r;
    res.cost   = ((AW+1)'(pj) > used) ? AW'((AW+1)'(pj) - used) : '0;
  end
endmodule

/* hdl/dirty_rectangle_grouper.sv */
// top level of the dirty rectangle grouper: sequencer, rectangle ram, join unit
// depends on drg_pkg, drg_ram, drg_join and dirty_rectangle_grouper_assert.svh
//
// channel | direction | handshake          | payload
// in      | input     | in_valid/in_ready  | drg_in_t
// out     | output    | out_valid/out_ready| drg_out_t
// cfg     | input     | cfg_we, no wait    | max_rectangles (4 bits)
//
// every entry access goes through the one ram read port; the containment scan,
// summary pass and ripple pass take each entry, and the cheapest-pair search each
// pair, through the two-stage join unit, which then joins the chosen pair.
// a merge writes the joined box and moves the last entry into the freed slot.
// a read, set or clear runs only the summary pass before giving its result.
// rst_n is synchronous, clears count and control and sets the limit to 15; ram content stays.
// in_ready is high while the sequencer idles; a finished result waits in the
// output register and the sequencer holds in its output state until it is free.
module dirty_rectangle_grouper
  import drg_pkg::*;
#(
  parameter int STORED_RECTS = STORED_RECTS_DEF,
  parameter int MAX_DIM      = MAX_DIM_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  drg_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output drg_out_t out_data,
  input  logic     cfg_we,
  input  logic [3:0] cfg_wdata
);
`include "dirty_rectangle_grouper_assert.svh"
  localparam int IW = $clog2(STORED_RECTS);
  localparam int NW = IW + 1;
  localparam int LIM = STORED_RECTS - 1;

  typedef enum logic [5:0] {
    S_IDLE, S_CONT_RD, S_CONT_W1, S_CONT_W2, S_CONT_CHK,
    S_APPEND, S_RIP_START, S_RIP_CUR, S_RIP_RD, S_RIP_W1, S_RIP_W2, S_RIP_CHK,
    S_MRG_WR, S_MRG_MOVE_RD, S_MRG_MOVE_W, S_MRG_MOVE_WR,
    S_LIM_CHK, S_PAIR_RDA, S_PAIR_WA, S_PAIR_LD, S_PAIR_W, S_PAIR_CHK,
    S_PJ_RDA, S_PJ_RDB, S_PJ_LD, S_PJ_W, S_PJ_CHK,
    S_SUM_RD, S_SUM_W1, S_SUM_W2, S_SUM_CHK, S_OUT
  } state_t;

  state_t        state_r;
  logic [NW-1:0] cnt_r;
  logic [3:0]    max_r;
  drg_in_t       req_r;
  logic [CW-1:0] px_r, py_r;
  logic [NW-1:0] i_r, j_r, cur_r, bi_r, bj_r;
  logic          pair_found_r, after_pair_r;
  logic [AW-1:0] best_r, total_r;
  box_t          hold_r, bnd_r, sel_r;
  box_t          ja_r, jb_r;
  drg_out_t      out_r;
  logic          out_valid_r;

  logic          we;
  logic [IW-1:0] waddr, raddr;
  box_t          wdata, rdata;
  join_res_t     jres;
  logic [NW-1:0] lim;
  logic [NW-1:0] i_dec;
  logic          out_load;

  drg_ram #(.WIDTH($bits(box_t)), .DEPTH(STORED_RECTS)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  drg_join u_join (.clk(clk), .a(ja_r), .b(jb_r), .res(jres));

  function automatic logic [CW-1:0] sat(input logic [14:0] v);
    logic [31:0] m;
    m = (MAX_DIM > 32767) ? 32'd32767 : 32'(MAX_DIM);
    return (32'(v) > m) ? CW'(m) : CW'(v);
  endfunction

  // limit in use, clamped to 1 .. STORED_RECTS-1
  always_comb begin
    if (max_r == 4'd0) begin
      lim = NW'(1);
    end else if (32'(max_r) > LIM) begin
      lim = NW'(LIM);
    end else begin
      lim = NW'(max_r);
    end
  end

  assign i_dec = i_r - NW'(1);

  // ram write port: driven from state, and by a set request while idle
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = hold_r;
    case (state_r)
      S_APPEND: begin
        we    = 1'b1;
        waddr = cnt_r[IW-1:0];
        wdata = '{x: px_r, y: py_r, w: CW'(1), h: CW'(1)};
      end
      S_MRG_WR: begin
        we    = 1'b1;
        waddr = bi_r[IW-1:0];
        wdata = hold_r;
      end
      S_MRG_MOVE_WR: begin
        we    = 1'b1;
        waddr = bj_r[IW-1:0];
        wdata = hold_r;
      end
      default: begin
        we = 1'b0;
      end
    endcase
    if (state_r == S_IDLE && in_valid && op_t'(in_data.op) == OP_SET) begin
      we    = 1'b1;
      waddr = '0;
      wdata = '{x: sat(in_data.pos_x), y: sat(in_data.pos_y),
                w: sat(in_data.size_w), h: sat(in_data.size_h)};
    end
  end

  // ram read address
  always_comb begin
    case (state_r)
      S_CONT_RD, S_SUM_RD, S_PAIR_RDA: raddr = i_r[IW-1:0];
      S_RIP_RD:                        raddr = i_dec[IW-1:0];
      S_RIP_START:                     raddr = cur_r[IW-1:0];
      S_PAIR_WA:                       raddr = j_r[IW-1:0];
      S_PJ_RDA:                        raddr = bi_r[IW-1:0];
      S_PJ_RDB:                        raddr = bj_r[IW-1:0];
      S_MRG_MOVE_RD:                   raddr = cnt_r[IW-1:0];
      default:                         raddr = '0;
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // sequencer: state, counters and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      max_r       <= 4'd15;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req_r <= in_data;
            px_r  <= sat(in_data.pos_x);
            py_r  <= sat(in_data.pos_y);
            i_r   <= '0;
            case (op_t'(in_data.op))
              OP_ADD: begin
                state_r <= S_CONT_RD;
              end
              OP_SET: begin
                cnt_r   <= NW'(1);
                state_r <= S_SUM_RD;
              end
              OP_CLEAR: begin
                cnt_r   <= '0;
                state_r <= S_SUM_RD;
              end
              default: begin
                state_r <= S_SUM_RD;
              end
            endcase
            total_r <= '0;
            bnd_r   <= '0;
            sel_r   <= '0;
            after_pair_r <= 1'b0;
          end
        end
        // containment scan
        S_CONT_RD: begin
          if (i_r >= cnt_r) begin
            state_r <= (cnt_r >= NW'(STORED_RECTS)) ? S_SUM_RD : S_APPEND;
            i_r     <= '0;
          end else begin
            state_r <= S_CONT_W1;
          end
        end
        S_CONT_W1: begin
          ja_r    <= rdata;
          jb_r    <= '{x: px_r, y: py_r, w: '0, h: '0};
          state_r <= S_CONT_W2;
        end
        S_CONT_W2: state_r <= S_CONT_CHK;
        S_CONT_CHK: begin
          if (jres.covers) begin
            i_r     <= '0;
            state_r <= S_SUM_RD;
          end else begin
            i_r     <= i_r + NW'(1);
            state_r <= S_CONT_RD;
          end
        end
        S_APPEND: begin
          cur_r   <= cnt_r;
          cnt_r   <= cnt_r + NW'(1);
          state_r <= S_RIP_START;
        end
        // ripple: fetch cur, then scan down from the top
        S_RIP_START: begin
          i_r     <= cnt_r;
          state_r <= S_RIP_CUR;
        end
        S_RIP_CUR: begin
          hold_r  <= rdata;
          state_r <= S_RIP_RD;
        end
        S_RIP_RD: begin
          if (i_r == '0) begin
            state_r <= S_LIM_CHK;
          end else begin
            i_r     <= i_dec;
            state_r <= (i_dec == cur_r) ? S_RIP_RD : S_RIP_W1;
          end
        end
        S_RIP_W1: begin
          ja_r    <= rdata;
          jb_r    <= hold_r;
          state_r <= S_RIP_W2;
        end
        S_RIP_W2: state_r <= S_RIP_CHK;
        S_RIP_CHK: begin
          if (jres.cost == '0) begin
            bi_r    <= (i_r < cur_r) ? i_r : cur_r;
            bj_r    <= (i_r < cur_r) ? cur_r : i_r;
            hold_r  <= jres.jbox;
            state_r <= S_MRG_WR;
          end else begin
            state_r <= S_RIP_RD;
          end
        end
        // merge: write joined box, move last entry into freed slot
        S_MRG_WR: begin
          cnt_r   <= cnt_r - NW'(1);
          cur_r   <= bi_r;
          state_r <= S_MRG_MOVE_RD;
        end
        S_MRG_MOVE_RD: begin
          state_r <= (bj_r != cnt_r) ? S_MRG_MOVE_W : S_RIP_START;
        end
        S_MRG_MOVE_W: begin
          hold_r  <= rdata;
          state_r <= S_MRG_MOVE_WR;
        end
        S_MRG_MOVE_WR: state_r <= S_RIP_START;
        // forced merge when over the limit, once per point
        S_LIM_CHK: begin
          if (!after_pair_r && cnt_r > lim) begin
            after_pair_r <= 1'b1;
            pair_found_r <= 1'b0;
            i_r          <= '0;
            j_r          <= NW'(1);
            bi_r         <= '0;
            bj_r         <= '0;
            best_r       <= '0;
            state_r      <= S_PAIR_RDA;
          end else begin
            i_r     <= '0;
            state_r <= S_SUM_RD;
          end
        end
        // cheapest-pair search, i ascending, j above i ascending
        S_PAIR_RDA: begin
          if (j_r >= cnt_r) begin
            if (i_r + NW'(2) >= cnt_r) begin
              state_r <= S_PJ_RDA;
            end else begin
              i_r <= i_r + NW'(1);
              j_r <= i_r + NW'(2);
            end
          end else begin
            state_r <= S_PAIR_WA;
          end
        end
        S_PAIR_WA: begin
          hold_r  <= rdata;
          state_r <= S_PAIR_LD;
        end
        S_PAIR_LD: begin
          ja_r    <= hold_r;
          jb_r    <= rdata;
          state_r <= S_PAIR_W;
        end
        S_PAIR_W: state_r <= S_PAIR_CHK;
        S_PAIR_CHK: begin
          if (!pair_found_r || jres.cost < best_r) begin
            pair_found_r <= 1'b1;
            bi_r   <= i_r;
            bj_r   <= j_r;
            best_r <= jres.cost;
          end
          j_r     <= j_r + NW'(1);
          state_r <= S_PAIR_RDA;
        end
        // join chosen pair: read bi then bj through the join unit
        S_PJ_RDA: state_r <= S_PJ_RDB;
        S_PJ_RDB: begin
          hold_r  <= rdata;
          state_r <= S_PJ_LD;
        end
        S_PJ_LD: begin
          ja_r    <= hold_r;
          jb_r    <= rdata;
          state_r <= S_PJ_W;
        end
        S_PJ_W: state_r <= S_PJ_CHK;
        S_PJ_CHK: begin
          hold_r  <= jres.jbox;
          state_r <= S_MRG_WR;
        end
        // summary pass over all entries
        S_SUM_RD: begin
          if (i_r >= cnt_r) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_SUM_W1;
          end
        end
        S_SUM_W1: begin
          ja_r    <= rdata;
          jb_r    <= (i_r == '0) ? rdata : bnd_r;
          if (32'(i_r) == 32'(req_r.index)) begin
            sel_r <= rdata;
          end
          state_r <= S_SUM_W2;
        end
        S_SUM_W2: state_r <= S_SUM_CHK;
        S_SUM_CHK: begin
          total_r <= total_r + jres.area_a;
          bnd_r   <= jres.jbox;
          i_r     <= i_r + NW'(1);
          state_r <= S_SUM_RD;
        end
        S_OUT: begin
          if (out_load) begin
            out_r.count      <= 4'(cnt_r);
            out_r.rect_x     <= sel_r.x[14:0];
            out_r.rect_y     <= sel_r.y[14:0];
            out_r.rect_w     <= sel_r.w[15:0];
            out_r.rect_h     <= sel_r.h[15:0];
            out_r.bound_x    <= bnd_r.x[14:0];
            out_r.bound_y    <= bnd_r.y[14:0];
            out_r.bound_w    <= bnd_r.w[15:0];
            out_r.bound_h    <= bnd_r.h[15:0];
            out_r.total_area <= total_r;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `DRG_ASSERT(a_cnt_range, cnt_r <= NW'(STORED_RECTS), "rectangle count above store size")
  `DRG_ASSERT(a_busy_no_ready, state_r != S_IDLE |-> !in_ready, "ready while sequencer busy")
  `DRG_ASSERT(a_out_from_seq, $rose(out_valid) |-> $past(state_r) == S_OUT, "result without sequencer")
  `DRG_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == S_IDLE && !out_valid, "reset left block busy")
endmodule
